/* rtl/text_display_escaper_defines.svh */
// Assertion helpers for the text display escaper.
// Each helper expects i_clk and i_rst_n in scope.
`ifndef TEXT_DISPLAY_ESCAPER_DEFINES_SVH
`define TEXT_DISPLAY_ESCAPER_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define TDE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("text_display_escaper: check failed");

// Next-cycle implication, checked outside reset
`define TDE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("text_display_escaper: check failed");

`endif

/* rtl/tde_pkg.sv */
package tde_pkg;

    // Line counter digits and derived widths
    localparam int NumDigits = 6;
    localparam int BcdW      = 4 * NumDigits;
    localparam int StepW     = $clog2(NumDigits + 3);

    // Sequencer positions after the digits
    localparam logic [StepW-1:0] StepTab    = StepW'(NumDigits);
    localparam logic [StepW-1:0] StepPrefix = StepW'(NumDigits + 1);
    localparam logic [StepW-1:0] StepFinal  = StepW'(NumDigits + 2);

    // Command queue depth
    localparam int QDepth = 2;
    localparam int QPtrW  = $clog2(QDepth);
    localparam int QCntW  = $clog2(QDepth + 1);

    // Configuration register map
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 2;
    localparam logic [CfgIdxW-1:0] RegLineNumbering = 3'd0;
    localparam logic [CfgIdxW-1:0] RegSqueezeBlank  = 3'd1;
    localparam logic [CfgIdxW-1:0] RegShowEnds      = 3'd2;
    localparam logic [CfgIdxW-1:0] RegShowTabs      = 3'd3;
    localparam logic [CfgIdxW-1:0] RegShowControl   = 3'd4;

    // Numbering modes
    localparam logic [1:0] NumberAll = 2'd1;

    // Characters
    localparam logic [7:0] ChTab      = 8'h09;
    localparam logic [7:0] ChNewline  = 8'h0A;
    localparam logic [7:0] ChSpace    = 8'h20;
    localparam logic [7:0] ChDollar   = 8'h24;
    localparam logic [7:0] ChZero     = 8'h30;
    localparam logic [7:0] ChQuestion = 8'h3F;
    localparam logic [7:0] ChCapI     = 8'h49;
    localparam logic [7:0] ChCaret    = 8'h5E;
    localparam logic [7:0] ChDel      = 8'h7F;
    localparam logic [7:0] CaretOff   = 8'h40;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       file_start;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } t_out;

    typedef struct packed {
        logic [1:0] line_numbering;
        logic       squeeze_blank;
        logic       show_ends;
        logic       show_tabs;
        logic       show_control;
    } t_cfg;

    // One classified item, as handed from front to back
    typedef struct packed {
        logic            numbered;
        logic [BcdW-1:0] bcd;
        logic            has_prefix;
        logic [7:0]      prefix;
        logic [7:0]      final_byte;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

endpackage

/* rtl/tde_front.sv */
module tde_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tde_pkg::t_cfg     i_cfg,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  tde_pkg::t_in      i_in_data,
    input  tde_pkg::t_q_stat  i_q_stat,
    output logic              o_push,
    output tde_pkg::t_cmd     o_cmd
);

    // Saturating BCD increment
    function automatic logic [tde_pkg::BcdW-1:0] bump(input logic [tde_pkg::BcdW-1:0] v);
        logic [tde_pkg::BcdW-1:0] r;
        logic                     carry;
        logic                     full;
        r     = v;
        carry = 1'b1;
        full  = 1'b1;
        for (int k = 0; k < tde_pkg::NumDigits; k++) begin
            if (v[4*k +: 4] != 4'd9) begin
                full = 1'b0;
            end
            if (carry) begin
                if (v[4*k +: 4] == 4'd9) begin
                    r[4*k +: 4] = 4'd0;
                end else begin
                    r[4*k +: 4] = v[4*k +: 4] + 4'd1;
                    carry       = 1'b0;
                end
            end
        end
        return full ? v : r;
    endfunction

    logic                     r_after_nl;
    logic [1:0]               r_empty_run;
    logic [tde_pkg::BcdW-1:0] r_bcd;

    logic                     n_after_nl;
    logic [1:0]               n_empty_run;
    logic [tde_pkg::BcdW-1:0] n_bcd;

    logic                     accept;
    logic                     drop;
    logic                     numbered;
    logic                     is_nl;
    logic                     squeeze_hit;
    logic                     cur_an;
    logic [1:0]               cur_er;
    logic [1:0]               er_inc;
    logic [tde_pkg::BcdW-1:0] cur_bcd;
    logic [7:0]               b;

    assign o_in_ready = !i_q_stat.full;
    assign accept     = i_in_valid && o_in_ready;

    // Classify the beat and work out the line state it leaves
    always_comb begin
        b       = i_in_data.in_byte;
        cur_an  = i_in_data.file_start ? 1'b1 : r_after_nl;
        cur_er  = i_in_data.file_start ? 2'd0 : r_empty_run;
        cur_bcd = i_in_data.file_start ? '0 : r_bcd;
        is_nl   = (b == tde_pkg::ChNewline);

        squeeze_hit = i_cfg.squeeze_blank && is_nl && cur_an;
        er_inc      = (cur_er < 2'd2) ? cur_er + 2'd1 : cur_er;
        n_empty_run = squeeze_hit ? er_inc : 2'd0;
        drop        = squeeze_hit && (er_inc == 2'd2);

        if (i_cfg.line_numbering[1]) begin
            numbered = cur_an && !is_nl && !drop;
        end else begin
            numbered = (i_cfg.line_numbering == tde_pkg::NumberAll) && cur_an && !drop;
        end

        n_bcd      = numbered ? bump(cur_bcd) : cur_bcd;
        n_after_nl = drop ? cur_an : is_nl;

        o_cmd.numbered   = numbered;
        o_cmd.bcd        = n_bcd;
        o_cmd.has_prefix = 1'b0;
        o_cmd.prefix     = tde_pkg::ChCaret;
        o_cmd.final_byte = b;

        // Pick the escape prefix and the shown byte
        priority if (i_cfg.show_tabs && b == tde_pkg::ChTab) begin
            o_cmd.has_prefix = 1'b1;
            o_cmd.final_byte = tde_pkg::ChCapI;
        end else if (i_cfg.show_ends && is_nl) begin
            o_cmd.has_prefix = 1'b1;
            o_cmd.prefix     = tde_pkg::ChDollar;
        end else if (i_cfg.show_control && (b < tde_pkg::ChTab
                     || (b > tde_pkg::ChNewline && b < tde_pkg::ChSpace))) begin
            o_cmd.has_prefix = 1'b1;
            o_cmd.final_byte = b + tde_pkg::CaretOff;
        end else if (i_cfg.show_control && b == tde_pkg::ChDel) begin
            o_cmd.has_prefix = 1'b1;
            o_cmd.final_byte = tde_pkg::ChQuestion;
        end else begin
            o_cmd.has_prefix = 1'b0;
        end

        o_push = accept && !drop;
    end

    // Update line state on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_after_nl  <= 1'b1;
            r_empty_run <= 2'd0;
            r_bcd       <= '0;
        end else if (accept) begin
            r_after_nl  <= n_after_nl;
            r_empty_run <= n_empty_run;
            r_bcd       <= n_bcd;
        end
    end

endmodule

/* rtl/tde_queue.sv */
module tde_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  tde_pkg::t_cmd     i_cmd,
    input  logic              i_pop,
    output tde_pkg::t_cmd     o_head,
    output tde_pkg::t_q_stat  o_stat
);

    tde_pkg::t_cmd             r_mem [tde_pkg::QDepth];
    logic [tde_pkg::QPtrW-1:0] r_wr;
    logic [tde_pkg::QPtrW-1:0] r_rd;
    logic [tde_pkg::QCntW-1:0] r_cnt;

    logic do_push;
    logic do_pop;

    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.full  = (r_cnt == tde_pkg::QCntW'(tde_pkg::QDepth));
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_head       = r_mem[r_rd];

    // Store pushed commands
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == tde_pkg::QPtrW'(tde_pkg::QDepth - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == tde_pkg::QPtrW'(tde_pkg::QDepth - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

/* rtl/tde_back.sv */
module tde_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tde_pkg::t_cmd  i_head,
    input  logic           i_head_valid,
    output logic           o_pop,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output tde_pkg::t_out  o_out_data
);

    logic [tde_pkg::StepW-1:0] r_step;
    logic                      r_mid;
    logic                      r_out_valid;
    tde_pkg::t_out             r_out;

    logic [tde_pkg::StepW-1:0] start_step;
    logic [tde_pkg::StepW-1:0] eff_step;
    logic [tde_pkg::StepW-1:0] n_step;
    tde_pkg::t_out             n_out;
    logic                      slot_free;
    logic                      fire;

    // Select the byte for the current position of the head command
    always_comb begin
        if (i_head.numbered) begin
            start_step = '0;
        end else if (i_head.has_prefix) begin
            start_step = tde_pkg::StepPrefix;
        end else begin
            start_step = tde_pkg::StepFinal;
        end
        eff_step  = r_mid ? r_step : start_step;
        slot_free = !r_out_valid || i_out_ready;
        fire      = i_head_valid && slot_free;

        n_out.out_byte    = tde_pkg::ChSpace;
        n_out.last_of_run = 1'b0;
        n_step            = eff_step + 1'b1;

        priority if (eff_step == tde_pkg::StepFinal) begin
            n_out.out_byte    = i_head.final_byte;
            n_out.last_of_run = 1'b1;
        end else if (eff_step == tde_pkg::StepPrefix) begin
            n_out.out_byte = i_head.prefix;
        end else if (eff_step == tde_pkg::StepTab) begin
            n_out.out_byte = tde_pkg::ChTab;
            n_step         = i_head.has_prefix ? tde_pkg::StepPrefix : tde_pkg::StepFinal;
        end else begin
            // Digit, most significant first; blank leading zeros
            for (int k = 0; k < tde_pkg::NumDigits; k++) begin
                if (eff_step == tde_pkg::StepW'(tde_pkg::NumDigits - 1 - k)) begin
                    if (k != 0 && (i_head.bcd >> (4 * k)) == '0) begin
                        n_out.out_byte = tde_pkg::ChSpace;
                    end else begin
                        n_out.out_byte = tde_pkg::ChZero + {4'd0, i_head.bcd[4*k +: 4]};
                    end
                end
            end
        end

        o_pop = fire && n_out.last_of_run;
    end

    // Sequencer and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= '0;
            r_mid       <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_step      <= n_step;
            r_mid       <= !n_out.last_of_run;
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Hold the output beat
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

/* rtl/text_display_escaper.sv */
// Text display escaper: turns a raw byte stream into its display form.
// Input channel (i_in_valid / o_in_ready / i_in_data) carries one byte per
// beat plus file_start, which clears line state before that byte.
// Output channel (o_out_valid / i_out_ready / o_out_data) carries one shown
// byte per beat; last_of_run marks the final byte caused by an input byte.
// An input byte yields zero to nine output bytes: an optional six-place line
// number and tab, an optional '^' or '$', then the shown byte.
// Options live in five registers written through i_cfg_we / i_cfg_index /
// i_cfg_data; the user must write them only while the block is idle, which
// the block itself does not enforce. Unknown indexes are ignored.
// An accepted byte passes the command queue, then the output register.
// Throughput: one input byte per cycle while each yields one output byte
// and the receiver is ready; an item of n output bytes holds the output
// sequencer until all n are sent; the two-entry queue absorbs the difference.
// When the receiver stalls, the output register holds its beat, the queue
// fills, and o_in_ready drops once both queue entries are taken.
// Reset (synchronous, active low) clears all options, the line counter,
// and the queue; line state starts as if a newline had just been seen.
`include "text_display_escaper_defines.svh"

module text_display_escaper (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  tde_pkg::t_in                   i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output tde_pkg::t_out                  o_out_data,
    input  logic                           i_cfg_we,
    input  logic [tde_pkg::CfgIdxW-1:0]    i_cfg_index,
    input  logic [tde_pkg::CfgDataW-1:0]   i_cfg_data
);

    tde_pkg::t_cfg    r_cfg;
    tde_pkg::t_cmd    push_cmd;
    tde_pkg::t_cmd    head_cmd;
    tde_pkg::t_q_stat q_stat;
    logic             push;
    logic             pop;

    // Configuration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tde_pkg::RegLineNumbering: r_cfg.line_numbering <= i_cfg_data;
                tde_pkg::RegSqueezeBlank:  r_cfg.squeeze_blank  <= i_cfg_data[0];
                tde_pkg::RegShowEnds:      r_cfg.show_ends      <= i_cfg_data[0];
                tde_pkg::RegShowTabs:      r_cfg.show_tabs      <= i_cfg_data[0];
                tde_pkg::RegShowControl:   r_cfg.show_control   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    tde_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_q_stat   (q_stat),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    tde_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_head  (head_cmd),
        .o_stat  (q_stat)
    );

    tde_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head_cmd),
        .i_head_valid (!q_stat.empty),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_data   (o_out_data)
    );

    // Back never retires a command the queue does not hold
    `TDE_ASSERT_IMP(a_pop_nonempty, pop, !q_stat.empty)

    // A command pushed into an idle path passes the queue and the output register, then shows up on the output
    `TDE_ASSERT_IMP(a_push_latency, push && q_stat.empty && !o_out_valid, ##2 o_out_valid)

    // Final beat taken with nothing queued leaves the output empty
    `TDE_ASSERT_NEXT(a_drain_idle,
        o_out_valid && i_out_ready && o_out_data.last_of_run && q_stat.empty && !push,
        !o_out_valid)

endmodule
